>>> rtl/core/dtk_pkg.sv
// Shared types and constants of the detection keep-top-k block.
// Used by dtk_store, dtk_cmp and detection_top_k_keeper; no dependencies.
`default_nettype none
package dtk_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int LABEL_W = 8;
	localparam int SCORE_W = 16;
	localparam int BOX_W = 14;
	localparam int KEEP_W = 8;
	localparam int IMG_W = 16;
	localparam logic [KEEP_W-1:0] KEEP_ALL = 8'hFF;

	// one stored detection
	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [SCORE_W-1:0] score;
		logic [BOX_W-1:0]   box;
	} entry_t;

	// control from the sequencer to the compare unit
	typedef struct packed {
		logic restart;
		logic commit;
		logic cand_valid;
	} cmp_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/detection_top_k_keeper.sv
// Keep-top-k stage: collects detections per image, emits the kept ones on the closing request.
// A detection request is taken only while idle. A closing request keeps busy while the kept
// entries are read in arrival order or, when sorted, for keep picks: each pick is one scan of
// the n stored entries through the single read port of the store and the shared compare unit.
// Results pass the read and output registers, one strobe cycle each; the receiver cannot stall.
// Reset (arst_n low) empties the store, clears the image counter and sets keep_limit to -1.
`default_nettype none
module detection_top_k_keeper #(
	parameter int STORE_DEPTH = dtk_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          keep_limit_wr,
	input  wire logic [dtk_pkg::KEEP_W-1:0]    keep_limit,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [dtk_pkg::LABEL_W-1:0]   class_label,
	input  wire logic [dtk_pkg::SCORE_W-1:0]   confidence,
	input  wire logic [dtk_pkg::BOX_W-1:0]     box_index,
	input  wire logic                          carries_detection,
	input  wire logic                          image_end,
	output logic                               result_strobe,
	output logic [dtk_pkg::IMG_W-1:0]          image_number,
	output logic [dtk_pkg::LABEL_W-1:0]        out_label,
	output logic [dtk_pkg::SCORE_W-1:0]        out_confidence,
	output logic [dtk_pkg::BOX_W-1:0]          out_box_index,
	output logic                               last_of_image,
	output logic                               overflowed
);
	import dtk_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int CMPW = (CW > KEEP_W) ? CW + 1 : KEEP_W + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SEQ  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_PICK = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     count_q;
	logic              ov_q;
	logic [IMG_W-1:0]  img_q;
	logic [KEEP_W-1:0] keep_limit_q;
	logic [CW-1:0]     keep_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     sent_q;
	logic              pend_s1;
	logic              last_s1;
	logic [AW-1:0]     idx_s1;
	logic              strobe_q;
	logic              last_q;
	entry_t            out_q;
	logic [IMG_W-1:0]  img_out_q;
	logic              ov_out_q;

	logic              accept;
	logic              has_room;
	logic              wr_det;
	logic              drop_det;
	logic [CW-1:0]     n_new;
	logic              ov_new;
	logic              do_sort;
	logic [CW-1:0]     keep_new;
	logic              load_out;
	entry_t            wdata;
	entry_t            rdata;
	entry_t            best;
	cmp_ctrl_t         cmp_ctrl;

	// request decode and close decision
	always_comb begin
		busy = (state_q != S_IDLE);
		accept = start && !busy;
		has_room = (count_q < CW'(STORE_DEPTH));
		wr_det = accept && carries_detection && has_room;
		drop_det = accept && carries_detection && !has_room;
		n_new = count_q + CW'(wr_det);
		ov_new = ov_q | drop_det;
		do_sort = !keep_limit_q[KEEP_W-1] && (CMPW'(n_new) > CMPW'(keep_limit_q));
		keep_new = do_sort ? CW'(keep_limit_q) : n_new;
		wdata = '{label: class_label, score: confidence, box: box_index};
		cmp_ctrl.restart = accept && image_end;
		cmp_ctrl.commit = (state_q == S_PICK);
		cmp_ctrl.cand_valid = (state_q == S_SCAN) && pend_s1;
		load_out = ((state_q == S_SEQ) && pend_s1) || (state_q == S_PICK);
	end

	dtk_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
		.clk     (clk),
		.we      (wr_det),
		.waddr   (count_q[AW-1:0]),
		.wdata   (wdata),
		.raddr   (ptr_q[AW-1:0]),
		.rdata_q (rdata)
	);

	dtk_cmp #(.AW(AW)) u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (cmp_ctrl),
		.cand     (rdata),
		.cand_idx (idx_s1),
		.best     (best)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q <= 1'b0;
			img_q <= '0;
			keep_limit_q <= KEEP_ALL;
			keep_q <= '0;
			ptr_q <= '0;
			sent_q <= '0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (keep_limit_wr) begin
				keep_limit_q <= keep_limit;
			end
			strobe_q <= 1'b0;
			last_q <= 1'b0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= n_new;
						ov_q <= ov_new;
						if (image_end) begin
							ptr_q <= '0;
							sent_q <= '0;
							keep_q <= keep_new;
							if (keep_new == '0) begin
								// nothing kept: close the image at once
								count_q <= '0;
								ov_q <= 1'b0;
								img_q <= img_q + 1'b1;
							end else begin
								state_q <= do_sort ? S_SCAN : S_SEQ;
							end
						end
					end
				end
				S_SEQ: begin
					// issue reads in arrival order
					if (ptr_q < keep_q) begin
						ptr_q <= ptr_q + 1'b1;
						pend_s1 <= 1'b1;
						last_s1 <= (CW'(ptr_q + 1'b1) == keep_q);
					end
					if (pend_s1) begin
						strobe_q <= 1'b1;
						last_q <= last_s1;
						if (last_s1) begin
							count_q <= '0;
							ov_q <= 1'b0;
							img_q <= img_q + 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					// feed every stored entry through the compare unit
					if (ptr_q < count_q) begin
						ptr_q <= ptr_q + 1'b1;
						pend_s1 <= 1'b1;
						last_s1 <= (CW'(ptr_q + 1'b1) == count_q);
					end
					if (pend_s1 && last_s1) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					// emit the winner, then rescan or close
					strobe_q <= 1'b1;
					last_q <= (CW'(sent_q + 1'b1) == keep_q);
					sent_q <= sent_q + 1'b1;
					ptr_q <= '0;
					if (CW'(sent_q + 1'b1) == keep_q) begin
						count_q <= '0;
						ov_q <= 1'b0;
						img_q <= img_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// index of the entry whose data arrives next cycle
	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q[AW-1:0];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= (state_q == S_PICK) ? best : rdata;
			img_out_q <= img_q;
			ov_out_q <= ov_q;
		end
	end

	assign result_strobe = strobe_q;
	assign last_of_image = last_q;
	assign image_number = img_out_q;
	assign out_label = out_q.label;
	assign out_confidence = out_q.score;
	assign out_box_index = out_q.box;
	assign overflowed = ov_out_q;

	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q != S_IDLE)) else $error("result while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH)) else $error("stored count beyond depth");

	a_sort_cut: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_PICK) |-> (keep_q < count_q))
		else $error("sorting without a cut");

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		last_of_image |-> result_strobe) else $error("last flag without result");

endmodule
`default_nettype wire

>>> rtl/core/dtk_store.sv
// Detection store: one write port, one read port with registered data.
// Depends on dtk_pkg for the entry type.
`default_nettype none
module dtk_store #(
	parameter int DEPTH = dtk_pkg::STORE_DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire dtk_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output dtk_pkg::entry_t      rdata_q
);
	import dtk_pkg::*;

	entry_t mem [DEPTH];

	// write one detection
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read every cycle, data appears in the next cycle
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/dtk_cmp.sv
// Shared compare unit: finds the next detection in (score desc, arrival asc)
// order after the previously picked one, one candidate per cycle. Uses dtk_pkg.
`default_nettype none
module dtk_cmp #(
	parameter int AW = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dtk_pkg::cmp_ctrl_t ctrl,
	input  wire dtk_pkg::entry_t    cand,
	input  wire logic [AW-1:0]      cand_idx,
	output dtk_pkg::entry_t         best
);
	import dtk_pkg::*;

	entry_t             best_q;
	logic [AW-1:0]      best_idx_q;
	logic               found_q;
	logic [SCORE_W-1:0] prev_score_q;
	logic [AW-1:0]      prev_idx_q;
	logic               have_prev_q;
	logic               after_prev;
	logic               better;

	// candidate must rank below the last pick; strict greater keeps the earliest tie
	always_comb begin
		after_prev = !have_prev_q || (cand.score < prev_score_q)
			|| ((cand.score == prev_score_q) && (cand_idx > prev_idx_q));
		better = !found_q || (cand.score > best_q.score);
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else if (ctrl.restart) begin
			found_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else if (ctrl.commit) begin
			found_q <= 1'b0;
			have_prev_q <= 1'b1;
		end else if (ctrl.cand_valid && after_prev && better) begin
			found_q <= 1'b1;
		end
	end

	// hold best candidate and last pick
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			prev_score_q <= best_q.score;
			prev_idx_q <= best_idx_q;
		end else if (ctrl.cand_valid && after_prev && better) begin
			best_q <= cand;
			best_idx_q <= cand_idx;
		end
	end

	assign best = best_q;

	// a pick always has a winner behind it
	a_commit_found: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |-> found_q) else $error("commit without a found entry");

endmodule
`default_nettype wire
